// File: hdl/tcl_pkg.sv
package tcl_pkg;

    // default geometry
    localparam int ENTRIES_DEF = 256;
    localparam int WAYS_DEF    = 4;

    // front pipeline: hash width and remainder digits per stage
    localparam int HASH_W     = 32;
    localparam int MOD_STEP   = 4;
    localparam int MOD_STAGES = HASH_W / MOD_STEP;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // hash constants
    localparam logic [31:0] HASH_K_ZOOM = 32'h9e3779b9;
    localparam logic [31:0] HASH_K_COL  = 32'h85ebca6b;
    localparam logic [31:0] HASH_K_ROW  = 32'hc2b2ae35;
    localparam logic [31:0] HASH_K_MIX  = 32'h7feb352d;
    localparam int          HASH_SH_A   = 16;
    localparam int          HASH_SH_B   = 15;

    // request codes
    localparam logic [1:0] FN_PROBE   = 2'd0;
    localparam logic [1:0] FN_TOUCH   = 2'd1;
    localparam logic [1:0] FN_LOAD    = 2'd2;
    localparam logic [1:0] FN_PREWARM = 2'd3;

    // result status codes
    localparam logic [2:0] STS_HIT     = 3'd0;
    localparam logic [2:0] STS_MISS    = 3'd1;
    localparam logic [2:0] STS_FILL    = 3'd2;
    localparam logic [2:0] STS_EVICT   = 3'd3;
    localparam logic [2:0] STS_REFUSED = 3'd4;

    // request transfer
    typedef struct packed {
        logic [1:0]  func;
        logic [4:0]  tile_zoom;
        logic [29:0] tile_x;
        logic [29:0] tile_y;
        logic [31:0] frame;
    } req_t;

    // result transfer
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  entry_index;
        logic [4:0]  evicted_zoom;
        logic [29:0] evicted_x;
        logic [29:0] evicted_y;
    } rsp_t;

    // one way of a set as held in the tag memory
    typedef struct packed {
        logic        vld;
        logic [4:0]  tag_zoom;
        logic [29:0] tag_col;
        logic [29:0] tag_row;
        logic [31:0] use_stamp;
    } way_t;

    // back end sequencer
    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EVAL
    } back_state_t;

endpackage

// File: hdl/tcl_ram.sv
module tcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/tcl_front.sv
module tcl_front #(
    parameter int NSETS = 64,
    parameter int SET_W = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              hold,
    input  logic              in_valid,
    output logic              in_ready,
    input  tcl_pkg::req_t     in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output tcl_pkg::req_t     out_req,
    output logic [SET_W-1:0]  out_set
);

    localparam int PIPE = 2 + tcl_pkg::MOD_STAGES;
    localparam int HW   = tcl_pkg::HASH_W;
    localparam int MS   = tcl_pkg::MOD_STEP;
    localparam int MN   = tcl_pkg::MOD_STAGES;
    localparam logic [SET_W:0] NSETS_EXT = (SET_W + 1)'(NSETS);

    logic [PIPE-1:0]  vld_reg;
    tcl_pkg::req_t    req_reg [0:PIPE-1];
    logic [HW-1:0]    h1_reg;
    logic [HW-1:0]    h1_next;
    logic [HW-1:0]    m_reg;
    logic [HW-1:0]    m_next;
    logic [HW-1:0]    h3;
    logic [SET_W-1:0] rem_reg [0:MN-1];
    logic [SET_W-1:0] rem_next [0:MN-1];
    logic [HW-1:0]    hv_reg [0:MN-1];
    logic [SET_W-1:0] mod_rin [0:MN-1];
    logic [HW-1:0]    mod_hin [0:MN-1];
    logic             advance;

    // one remainder digit: shift in bits, subtract the set count when reached
    function automatic logic [SET_W-1:0] mod_step(input logic [SET_W-1:0] r,
                                                  input logic [MS-1:0] d);
        logic [SET_W:0]   t;
        logic [SET_W-1:0] acc;
        acc = r;
        for (int b = MS - 1; b >= 0; b--)
        begin
            t = {acc, d[b]};
            if (t >= NSETS_EXT)
            begin
                t = t - NSETS_EXT;
            end
            acc = t[SET_W-1:0];
        end
        return acc;
    endfunction

    // whole pipeline moves unless the last stage is blocked
    assign advance  = !vld_reg[PIPE-1] || out_ready;
    assign in_ready = advance && !hold;

    // hash stage one: key products
    assign h1_next = (32'(in_data.tile_zoom) * tcl_pkg::HASH_K_ZOOM)
                   ^ (32'(in_data.tile_x) * tcl_pkg::HASH_K_COL)
                   ^ (32'(in_data.tile_y) * tcl_pkg::HASH_K_ROW);

    // hash stage two: fold and mix
    assign m_next = (h1_reg ^ (h1_reg >> tcl_pkg::HASH_SH_A)) * tcl_pkg::HASH_K_MIX;

    // final fold feeds the remainder pipeline
    assign h3 = m_reg ^ (m_reg >> tcl_pkg::HASH_SH_B);

    // remainder stages, most significant digit first
    always_comb
    begin
        mod_rin[0] = '0;
        mod_hin[0] = h3;
        for (int k = 1; k < MN; k++)
        begin
            mod_rin[k] = rem_reg[k-1];
            mod_hin[k] = hv_reg[k-1];
        end
        for (int k = 0; k < MN; k++)
        begin
            rem_next[k] = mod_step(mod_rin[k], mod_hin[k][HW-1-k*MS -: MS]);
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[PIPE-2:0], in_valid && in_ready};
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            req_reg[0] <= in_data;
            for (int i = 1; i < PIPE; i++)
            begin
                req_reg[i] <= req_reg[i-1];
            end
            h1_reg <= h1_next;
            m_reg  <= m_next;
            for (int k = 0; k < MN; k++)
            begin
                rem_reg[k] <= rem_next[k];
                hv_reg[k]  <= mod_hin[k];
            end
        end
    end

    assign out_valid = vld_reg[PIPE-1];
    assign out_req   = req_reg[PIPE-1];
    assign out_set   = rem_reg[MN-1];

endmodule

// File: hdl/tcl_queue.sv
module tcl_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: hdl/tcl_back.sv
module tcl_back #(
    parameter int ENTRIES = 256,
    parameter int WAYS    = 4,
    parameter int NSETS   = 64,
    parameter int SET_W   = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  tcl_pkg::req_t    q_req,
    input  logic [SET_W-1:0] q_set,
    output logic             q_pop,
    output logic             clearing,
    output logic             out_valid,
    input  logic             out_ready,
    output tcl_pkg::rsp_t    out_data
);

    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LP      = 1 << $clog2(WAYS);
    localparam int ENTRY_W = $bits(tcl_pkg::way_t);
    localparam int ROW_W   = WAYS * ENTRY_W;
    localparam int IDX_W   = $clog2(ENTRIES) + 1;

    tcl_pkg::back_state_t state_reg;
    tcl_pkg::back_state_t state_next;

    logic [SET_W-1:0]     clr_cnt_reg;
    logic [SET_W-1:0]     clr_cnt_next;
    tcl_pkg::req_t        req_reg;
    logic [SET_W-1:0]     set_reg;
    logic                 out_valid_reg;
    tcl_pkg::rsp_t        out_data_reg;

    logic                 out_free;
    logic                 eval_fire;
    logic                 clr_done;

    logic                 ram_we;
    logic [SET_W-1:0]     ram_waddr;
    logic [ROW_W-1:0]     ram_wdata;
    logic                 ram_re;
    logic [ROW_W-1:0]     ram_rdata;

    tcl_pkg::way_t [WAYS-1:0] row;
    tcl_pkg::way_t [WAYS-1:0] wrow;

    logic                 hit;
    logic [WAY_W-1:0]     hit_way;
    logic                 has_free;
    logic [WAY_W-1:0]     free_way;
    logic [WAY_W-1:0]     lru_way;
    logic [31:0]          nd_stamp [0:2*LP-2];
    logic [WAY_W-1:0]     nd_way [0:2*LP-2];
    logic                 nd_live [0:2*LP-2];

    logic                 do_write;
    logic [WAY_W-1:0]     sel_way;
    tcl_pkg::rsp_t        rsp;
    logic [IDX_W-1:0]     idx;
    logic [IDX_W+7:0]     idx_ext;

    // set memory: one row holds every way of a set
    tcl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NSETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (q_set),
        .rdata (ram_rdata)
    );

    assign row       = ram_rdata;
    assign out_free  = !out_valid_reg || out_ready;
    assign clr_done  = (clr_cnt_reg == SET_W'(NSETS - 1));
    assign eval_fire = (state_reg == tcl_pkg::BK_EVAL) && out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcl_pkg::BK_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = tcl_pkg::BK_IDLE;
                end
            end
            tcl_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = tcl_pkg::BK_EVAL;
                end
            end
            tcl_pkg::BK_EVAL:
            begin
                if (out_free)
                begin
                    state_next = tcl_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = tcl_pkg::BK_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        q_pop        = 1'b0;
        ram_re       = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = set_reg;
        ram_wdata    = wrow;
        clearing     = 1'b0;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            tcl_pkg::BK_CLEAR:
            begin
                clearing     = 1'b1;
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            tcl_pkg::BK_IDLE:
            begin
                q_pop  = q_valid;
                ram_re = q_valid;
            end
            tcl_pkg::BK_EVAL:
            begin
                ram_we = out_free && do_write;
            end
            default:
            begin
                clearing = 1'b0;
            end
        endcase
    end

    // tag compare and free way, lowest way first
    always_comb
    begin
        hit      = 1'b0;
        hit_way  = '0;
        has_free = 1'b0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (row[w].vld && row[w].tag_zoom == req_reg.tile_zoom
                && row[w].tag_col == req_reg.tile_x && row[w].tag_row == req_reg.tile_y)
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!row[w].vld)
            begin
                has_free = 1'b1;
                free_way = WAY_W'(w);
            end
        end
    end

    // oldest stamp by a comparison tree, ties to the left
    always_comb
    begin
        for (int i = 0; i < LP; i++)
        begin
            nd_way[LP-1+i] = WAY_W'(i);
            if (i < WAYS)
            begin
                nd_live[LP-1+i]  = 1'b1;
                nd_stamp[LP-1+i] = row[i].use_stamp;
            end
            else
            begin
                nd_live[LP-1+i]  = 1'b0;
                nd_stamp[LP-1+i] = '1;
            end
        end
        for (int n = LP - 2; n >= 0; n--)
        begin
            if (nd_live[2*n+2] && (!nd_live[2*n+1] || nd_stamp[2*n+2] < nd_stamp[2*n+1]))
            begin
                nd_live[n]  = 1'b1;
                nd_stamp[n] = nd_stamp[2*n+2];
                nd_way[n]   = nd_way[2*n+2];
            end
            else
            begin
                nd_live[n]  = nd_live[2*n+1];
                nd_stamp[n] = nd_stamp[2*n+1];
                nd_way[n]   = nd_way[2*n+1];
            end
        end
        lru_way = nd_way[0];
    end

    // decision and write-back row
    always_comb
    begin
        rsp              = '0;
        rsp.status       = tcl_pkg::STS_MISS;
        sel_way          = '0;
        do_write         = 1'b0;
        wrow             = row;
        if (hit)
        begin
            rsp.status = tcl_pkg::STS_HIT;
            sel_way    = hit_way;
            if (req_reg.func != tcl_pkg::FN_PROBE)
            begin
                do_write                 = 1'b1;
                wrow[hit_way].use_stamp  = req_reg.frame;
            end
        end
        else if (req_reg.func == tcl_pkg::FN_LOAD || req_reg.func == tcl_pkg::FN_PREWARM)
        begin
            if (has_free)
            begin
                rsp.status = tcl_pkg::STS_FILL;
                sel_way    = free_way;
                do_write   = 1'b1;
            end
            else
            begin
                sel_way = lru_way;
                if (req_reg.func == tcl_pkg::FN_PREWARM
                    && ({1'b0, row[lru_way].use_stamp} + 33'd1) >= {1'b0, req_reg.frame})
                begin
                    rsp.status = tcl_pkg::STS_REFUSED;
                end
                else
                begin
                    rsp.status       = tcl_pkg::STS_EVICT;
                    rsp.evicted_zoom = row[lru_way].tag_zoom;
                    rsp.evicted_x    = row[lru_way].tag_col;
                    rsp.evicted_y    = row[lru_way].tag_row;
                    do_write         = 1'b1;
                end
            end
            if (do_write)
            begin
                wrow[sel_way].vld       = 1'b1;
                wrow[sel_way].tag_zoom  = req_reg.tile_zoom;
                wrow[sel_way].tag_col   = req_reg.tile_x;
                wrow[sel_way].tag_row   = req_reg.tile_y;
                wrow[sel_way].use_stamp = req_reg.frame;
            end
        end
        idx             = IDX_W'(set_reg) * IDX_W'(WAYS) + IDX_W'(sel_way);
        idx_ext         = {8'h00, idx};
        rsp.entry_index = idx_ext[7:0];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcl_pkg::BK_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (eval_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request and result holding registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            req_reg <= q_req;
            set_reg <= q_set;
        end
        if (eval_fire)
        begin
            out_data_reg <= rsp;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: hdl/tile_cache_lru_4way_core.sv
// channel   direction  signals                          payload
// request   in         in_valid / in_ready / in_data     tcl_pkg::req_t
// result    out        out_valid / out_ready / out_data  tcl_pkg::rsp_t
//
// hash and set-index pipeline, then a 4-deep queue in front of the set engine
// set engine: a read state fetches the set row, then an evaluate state compares, picks the way
// and writes the row back, so a new request is taken only once the last one is done
// after reset a clearing pass writes every set row once, ENTRIES/WAYS rows (64 by default),
// with in_ready low throughout
// a held result stalls the set engine only; requests fill the pipeline and queue behind it
module tile_cache_lru_4way_core #(
    parameter int ENTRIES = tcl_pkg::ENTRIES_DEF,
    parameter int WAYS    = tcl_pkg::WAYS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  tcl_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output tcl_pkg::rsp_t out_data
);

    localparam int NSETS = ENTRIES / WAYS;
    localparam int SET_W = (NSETS > 1) ? $clog2(NSETS) : 1;
    localparam int REQ_W = $bits(tcl_pkg::req_t);
    localparam int QW    = REQ_W + SET_W;

    logic             clearing;
    logic             fr_valid;
    tcl_pkg::req_t    fr_req;
    logic [SET_W-1:0] fr_set;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    logic [QW-1:0]    q_wdata;
    logic [QW-1:0]    q_rdata;
    tcl_pkg::req_t    q_req;
    logic [SET_W-1:0] q_set;

    // hash and set index
    tcl_front #(
        .NSETS (NSETS),
        .SET_W (SET_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .hold      (clearing),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (fr_valid),
        .out_ready (!q_full),
        .out_req   (fr_req),
        .out_set   (fr_set)
    );

    // decoupling queue
    assign q_wdata = {fr_req, fr_set};

    tcl_queue #(
        .WIDTH (QW),
        .DEPTH (tcl_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fr_valid),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign q_req = q_rdata[QW-1:SET_W];
    assign q_set = q_rdata[SET_W-1:0];

    // set engine
    tcl_back #(
        .ENTRIES (ENTRIES),
        .WAYS    (WAYS),
        .NSETS   (NSETS),
        .SET_W   (SET_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (!q_empty),
        .q_req     (q_req),
        .q_set     (q_set),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// File: hdl/tcl_checker.sv
module tcl_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input tcl_pkg::req_t in_data,
    input logic          out_valid,
    input logic          out_ready,
    input tcl_pkg::rsp_t out_data
);

    // a waiting request holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("request changed while waiting");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // status is a defined code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == tcl_pkg::STS_HIT
                    || out_data.status == tcl_pkg::STS_MISS
                    || out_data.status == tcl_pkg::STS_FILL
                    || out_data.status == tcl_pkg::STS_EVICT
                    || out_data.status == tcl_pkg::STS_REFUSED))
        else $error("undefined status code");

    // displaced key only shown on eviction
    a_evict_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != tcl_pkg::STS_EVICT
        |-> out_data.evicted_zoom == '0 && out_data.evicted_x == '0
            && out_data.evicted_y == '0)
        else $error("evicted key shown without eviction");

    // no request taken while the clearing pass starts
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !in_ready && !out_valid)
        else $error("request taken during clearing pass");

endmodule

bind tile_cache_lru_4way_core tcl_checker u_tcl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// File: tb/tile_cache_lru_4way_core_tb.sv
`timescale 1ns / 100ps

module tile_cache_lru_4way_core_tb;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 6;
    localparam int LINES          = 256;
    localparam int ASSOC          = 4;
    localparam int SETS           = LINES / ASSOC;
    localparam int PHASES         = 4;
    localparam int RAND_PER_PHASE = 408;
    localparam int HOT_SETS       = 6;
    localparam int KEYS_PER_HOT   = 7;
    localparam int WIDE_KEYS      = 96;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int REPORT_MAX     = 10;

    // set index hash multipliers and shifts
    localparam logic [31:0] MIX_ZOOM  = 32'h9e3779b9;
    localparam logic [31:0] MIX_COL   = 32'h85ebca6b;
    localparam logic [31:0] MIX_ROW   = 32'hc2b2ae35;
    localparam logic [31:0] MIX_FINAL = 32'h7feb352d;
    localparam int          SHIFT_A   = 16;
    localparam int          SHIFT_B   = 15;

    typedef struct packed {
        logic [4:0]  zoom;
        logic [29:0] col;
        logic [29:0] row;
    } tile_key_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    tcl_pkg::req_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    tcl_pkg::rsp_t out_data;

    // tag store mirror
    logic        line_vld   [LINES];
    logic [4:0]  line_zoom  [LINES];
    logic [29:0] line_col   [LINES];
    logic [29:0] line_row   [LINES];
    logic [31:0] line_stamp [LINES];

    tcl_pkg::req_t pending_reqs [$];
    tcl_pkg::rsp_t results_due  [$];
    logic        req_fired = 1'b0;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned mismatches = 0;
    int unsigned reqs_taken = 0;
    int unsigned results_seen = 0;
    int unsigned quiet_cycles = 0;
    int unsigned status_seen [0:4] = '{0, 0, 0, 0, 0};

    tile_cache_lru_4way_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // multiply-xorshift hash folded onto the set count
    function automatic int unsigned tile_set(tile_key_t k);
        logic [31:0] h;
        h = 32'(k.zoom) * MIX_ZOOM;
        h ^= 32'(k.col) * MIX_COL;
        h ^= 32'(k.row) * MIX_ROW;
        h ^= h >> SHIFT_A;
        h *= MIX_FINAL;
        h ^= h >> SHIFT_B;
        return h % SETS;
    endfunction

    // lookup, allocation and lru choice for one request; updates the mirror
    function automatic tcl_pkg::rsp_t cache_lookup(tcl_pkg::req_t r);
        tile_key_t     k;
        tcl_pkg::rsp_t res;
        int unsigned   base;
        int unsigned   slot;
        int unsigned   victim;
        int unsigned   spare;
        logic          found;
        logic          have_spare;
        k.zoom = r.tile_zoom;
        k.col = r.tile_x;
        k.row = r.tile_y;
        base = tile_set(k) * ASSOC;
        res = '0;
        res.status = tcl_pkg::STS_MISS;
        res.entry_index = 8'(base);
        found = 1'b0;
        have_spare = 1'b0;
        slot = base;
        victim = base;
        spare = base;
        for (int w = 0; w < ASSOC; w++)
        begin
            if (!found && line_vld[base + w] && line_zoom[base + w] == k.zoom
                && line_col[base + w] == k.col && line_row[base + w] == k.row)
            begin
                found = 1'b1;
                slot = base + w;
            end
        end
        if (found)
        begin
            res.status = tcl_pkg::STS_HIT;
            res.entry_index = 8'(slot);
            if (r.func != tcl_pkg::FN_PROBE)
                line_stamp[slot] = r.frame;
        end
        else if (r.func == tcl_pkg::FN_LOAD || r.func == tcl_pkg::FN_PREWARM)
        begin
            // lowest free way, else oldest stamp with ties to the lowest way
            for (int w = 0; w < ASSOC; w++)
            begin
                if (!line_vld[base + w])
                begin
                    if (!have_spare)
                    begin
                        have_spare = 1'b1;
                        spare = base + w;
                    end
                end
                else if (line_stamp[base + w] < line_stamp[victim])
                    victim = base + w;
            end
            if (have_spare)
            begin
                slot = spare;
                res.status = tcl_pkg::STS_FILL;
            end
            else
            begin
                slot = victim;
                // prewarm keeps entries used this frame or the last, no wrap
                if (r.func == tcl_pkg::FN_PREWARM
                    && ({1'b0, line_stamp[victim]} + 33'd1 >= {1'b0, r.frame}))
                    res.status = tcl_pkg::STS_REFUSED;
                else
                begin
                    res.status = tcl_pkg::STS_EVICT;
                    res.evicted_zoom = line_zoom[victim];
                    res.evicted_x = line_col[victim];
                    res.evicted_y = line_row[victim];
                end
            end
            res.entry_index = 8'(slot);
            if (res.status == tcl_pkg::STS_FILL || res.status == tcl_pkg::STS_EVICT)
            begin
                line_vld[slot] = 1'b1;
                line_zoom[slot] = k.zoom;
                line_col[slot] = k.col;
                line_row[slot] = k.row;
                line_stamp[slot] = r.frame;
            end
        end
        return res;
    endfunction

    function automatic string rsp_text(tcl_pkg::rsp_t r);
        return $sformatf("status=%0d entry=%0d evicted=(%0d,%h,%h)", r.status,
                         r.entry_index, r.evicted_zoom, r.evicted_x, r.evicted_y);
    endfunction

    function automatic tile_key_t random_key();
        tile_key_t k;
        k.zoom = 5'($urandom_range(0, 30));
        k.col = 30'($urandom);
        k.row = 30'($urandom);
        return k;
    endfunction

    function automatic tile_key_t key_in_set(int unsigned set_no);
        tile_key_t k;
        k = random_key();
        while (tile_set(k) != set_no)
            k = random_key();
        return k;
    endfunction

    task automatic queue_req(logic [1:0] fn, tile_key_t k, logic [31:0] frm);
        tcl_pkg::req_t r;
        r.func = fn;
        r.tile_zoom = k.zoom;
        r.tile_x = k.col;
        r.tile_y = k.row;
        r.frame = frm;
        pending_reqs.push_back(r);
    endtask

    // mostly keys crowded into a few sets, some spread keys, some fresh ones
    task automatic queue_random_phase(int unsigned count, logic [31:0] start_frame);
        tile_key_t   hot  [HOT_SETS * KEYS_PER_HOT];
        tile_key_t   wide [WIDE_KEYS];
        tile_key_t   k;
        logic [1:0]  fn;
        logic [31:0] now_frame;
        logic [31:0] frm;
        int unsigned pick;
        int unsigned hot_set;
        for (int s = 0; s < HOT_SETS; s++)
        begin
            hot_set = $urandom_range(0, SETS - 1);
            for (int j = 0; j < KEYS_PER_HOT; j++)
                hot[s * KEYS_PER_HOT + j] = key_in_set(hot_set);
        end
        foreach (wide[i])
            wide[i] = random_key();
        now_frame = start_frame;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
                fn = tcl_pkg::FN_PROBE;
            else if (pick < 40)
                fn = tcl_pkg::FN_TOUCH;
            else if (pick < 75)
                fn = tcl_pkg::FN_LOAD;
            else
                fn = tcl_pkg::FN_PREWARM;
            pick = $urandom_range(0, 99);
            if (pick < 70)
                k = hot[$urandom_range(0, HOT_SETS * KEYS_PER_HOT - 1)];
            else if (pick < 88)
                k = wide[$urandom_range(0, WIDE_KEYS - 1)];
            else
                k = random_key();
            // frames creep forward, with the odd step back or wild value
            pick = $urandom_range(0, 99);
            if (pick < 25)
                now_frame = now_frame + 1;
            else if (pick < 33)
                now_frame = now_frame + $urandom_range(2, 6);
            frm = now_frame;
            if (pick >= 96)
                frm = $urandom;
            else if (pick >= 91)
                frm = now_frame - $urandom_range(1, 4);
            queue_req(fn, k, frm);
        end
    endtask

    // sender holds off until every outstanding result has come back
    task automatic drain_all();
        while (pending_reqs.size() != 0 || in_valid || results_due.size() != 0)
            @(posedge clk);
    endtask

    // request driver and result-side backpressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || req_fired)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    in_data <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // result checking first, then prediction for the accepted request
    always @(posedge clk)
    begin
        tcl_pkg::rsp_t want;
        logic bad;
        req_fired <= in_valid && in_ready;
        if (out_valid && out_ready)
        begin
            results_seen++;
            if (results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result transfer: %s", rsp_text(out_data));
            end
            else
            begin
                want = results_due.pop_front();
                bad = (out_data.status !== want.status)
                    || (out_data.entry_index !== want.entry_index)
                    || (out_data.evicted_zoom !== want.evicted_zoom)
                    || (out_data.evicted_x !== want.evicted_x)
                    || (out_data.evicted_y !== want.evicted_y);
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("result %0d mismatch: expected %s, got %s", results_seen,
                                 rsp_text(want), rsp_text(out_data));
                end
            end
        end
        if (in_valid && in_ready)
        begin
            want = cache_lookup(in_data);
            results_due.push_back(want);
            status_seen[want.status]++;
            reqs_taken++;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, results_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        tile_key_t   dk [6];
        tile_key_t   key_max;
        tile_key_t   key_zero;
        int unsigned dset;
        logic [31:0] start_frame;
        foreach (line_vld[i])
        begin
            line_vld[i] = 1'b0;
            line_zoom[i] = '0;
            line_col[i] = '0;
            line_row[i] = '0;
            line_stamp[i] = '0;
        end
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // directed: one set walked through every outcome
        dset = $urandom_range(0, SETS - 1);
        foreach (dk[i])
            dk[i] = key_in_set(dset);
        key_max = '{5'd30, 30'h3FFFFFFF, 30'h3FFFFFFF};
        key_zero = '0;
        queue_req(tcl_pkg::FN_PROBE, dk[0], 32'd10);     // miss, nothing allocated
        queue_req(tcl_pkg::FN_TOUCH, dk[0], 32'd10);     // miss on touch
        queue_req(tcl_pkg::FN_LOAD, dk[0], 32'd10);      // first free way
        queue_req(tcl_pkg::FN_PROBE, dk[0], 32'd99);     // hit, stamp left alone
        queue_req(tcl_pkg::FN_TOUCH, dk[0], 32'd11);     // hit, restamped
        queue_req(tcl_pkg::FN_LOAD, dk[1], 32'd11);
        queue_req(tcl_pkg::FN_PREWARM, dk[2], 32'd11);   // prewarm into a free way
        queue_req(tcl_pkg::FN_LOAD, dk[3], 32'd11);      // set now full, all stamps equal
        queue_req(tcl_pkg::FN_LOAD, dk[4], 32'd12);      // tie goes to the lowest way
        queue_req(tcl_pkg::FN_PREWARM, dk[5], 32'd12);   // victim used last frame
        queue_req(tcl_pkg::FN_PREWARM, dk[5], 32'd5);    // victim stamp ahead of frame
        queue_req(tcl_pkg::FN_PREWARM, dk[5], 32'd13);   // victim old enough to go
        queue_req(tcl_pkg::FN_LOAD, dk[0], 32'd3);       // frame running backwards
        queue_req(tcl_pkg::FN_PREWARM, dk[2], 32'd1);
        queue_req(tcl_pkg::FN_LOAD, dk[4], 32'd20);      // hit on load
        queue_req(tcl_pkg::FN_PREWARM, dk[5], 32'd21);   // hit on prewarm
        queue_req(tcl_pkg::FN_LOAD, key_max, 32'hFFFFFFFF);
        queue_req(tcl_pkg::FN_PROBE, key_max, 32'h0);
        queue_req(tcl_pkg::FN_LOAD, key_zero, 32'h0);
        queue_req(tcl_pkg::FN_TOUCH, key_zero, 32'hFFFFFFFF);
        drain_all();

        // random phases, each under its own idle and stall mix
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                    start_frame = 32'd50;
                end
                1:
                begin
                    idle_pct = 78;
                    stall_pct = 0;
                    start_frame = $urandom;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 78;
                    start_frame = 32'hFFFFFF80;
                end
                default:
                begin
                    idle_pct = 24;
                    stall_pct = 24;
                    start_frame = $urandom;
                end
            endcase
            queue_random_phase(RAND_PER_PHASE, start_frame);
            drain_all();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("run covered %0d requests and %0d result transfers over %0d traffic mixes",
                 reqs_taken, results_seen, PHASES + 1);
        $display("outcomes: %0d hits, %0d misses, %0d fills, %0d evictions, %0d refused",
                 status_seen[tcl_pkg::STS_HIT], status_seen[tcl_pkg::STS_MISS],
                 status_seen[tcl_pkg::STS_FILL], status_seen[tcl_pkg::STS_EVICT],
                 status_seen[tcl_pkg::STS_REFUSED]);
        if (mismatches == 0 && results_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
